[sv/kfd_pkg.sv]
`timescale 1ns / 1ps

package kfd_pkg;

    localparam int BUFFER_SIZE = 256;
    localparam int IDX_W       = $clog2(BUFFER_SIZE + 1);

    localparam logic [7:0] KISS_FEND  = 8'hC0;
    localparam logic [7:0] KISS_FESC  = 8'hDB;
    localparam logic [7:0] KISS_TFEND = 8'hDC;
    localparam logic [7:0] KISS_TFESC = 8'hDD;
    localparam logic [7:0] KISS_CMD_DATA = 8'h00;

    typedef enum logic [1:0] {
        ST_HUNT   = 2'd0,
        ST_CMD    = 2'd1,
        ST_DATA   = 2'd2,
        ST_ESCAPE = 2'd3
    } parse_state_t;

    typedef struct packed {
        logic       store_valid;
        logic [7:0] store_byte;
        logic [7:0] store_index;
        logic       frame_ready;
        logic       frame_aborted;
        logic [8:0] frame_length;
    } result_t;

endpackage

[sv/kfd_byte_if.sv]
`timescale 1ns / 1ps

interface kfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

[sv/kfd_result_if.sv]
`timescale 1ns / 1ps

interface kfd_result_if;
    logic       valid;
    logic       ready;
    logic       store_valid;
    logic [7:0] store_byte;
    logic [7:0] store_index;
    logic       frame_ready;
    logic       frame_aborted;
    logic [8:0] frame_length;

    modport source (
        output valid, output store_valid, output store_byte, output store_index,
        output frame_ready, output frame_aborted, output frame_length,
        input ready
    );
    modport sink (
        input valid, input store_valid, input store_byte, input store_index,
        input frame_ready, input frame_aborted, input frame_length,
        output ready
    );
endinterface

[sv/kiss_frame_deframer.sv]
`timescale 1ns / 1ps
// A byte accepted into the input register is parsed by the FSM, and its result is
// captured in the result register, which drives the result port.
// Throughput: one byte per cycle while result.ready is high; the input and result
// registers each take a new transaction whenever the stage behind them moves on.
// Reset (rst_n low, asynchronous): the parser hunts for FEND, the write index
// and held length are zero, the address field is expected, and both stages are empty.

module kiss_frame_deframer (
    input  logic         clk,
    input  logic         rst_n,
    kfd_byte_if.sink     rx,
    kfd_result_if.source result
);

    logic             byte_valid;
    logic [7:0]       byte_data;
    logic             byte_take;
    kfd_pkg::result_t res;

    kfd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .byte_take  (byte_take)
    );

    kfd_fsm u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (byte_take),
        .byte_data (byte_data),
        .res       (res)
    );

    kfd_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (byte_valid),
        .res       (res),
        .res_take  (byte_take),
        .result    (result)
    );

endmodule

[sv/kfd_in_stage.sv]
`timescale 1ns / 1ps

module kfd_in_stage (
    input  logic        clk,
    input  logic        rst_n,
    kfd_byte_if.sink    rx,
    output logic        byte_valid,
    output logic [7:0]  byte_data,
    input  logic        byte_take
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    assign rx.ready   = !valid_reg || byte_take;
    assign valid_next = rx.valid || (valid_reg && !byte_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            data_reg <= rx.rx_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

[sv/kfd_fsm.sv]
`timescale 1ns / 1ps

module kfd_fsm (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        byte_data,
    output kfd_pkg::result_t  res
);

    kfd_pkg::parse_state_t     state_reg;
    kfd_pkg::parse_state_t     state_next;
    logic [kfd_pkg::IDX_W-1:0] index_reg;
    logic [kfd_pkg::IDX_W-1:0] index_next;
    logic                      addr_mode_reg;
    logic                      addr_mode_next;
    logic [8:0]                held_reg;
    logic [8:0]                held_next;
    logic                      do_put;
    logic [7:0]                put_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kfd_pkg::ST_HUNT;
            index_reg     <= '0;
            addr_mode_reg <= 1'b1;
            held_reg      <= '0;
        end
        else if (step)
        begin
            state_reg     <= state_next;
            index_reg     <= index_next;
            addr_mode_reg <= addr_mode_next;
            held_reg      <= held_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        index_next     = index_reg;
        addr_mode_next = addr_mode_reg;
        held_next      = held_reg;
        do_put         = 1'b0;
        put_byte       = byte_data;
        res            = '0;

        case (state_reg)
            kfd_pkg::ST_HUNT:
            begin
                if (byte_data == kfd_pkg::KISS_FEND)
                begin
                    state_next = kfd_pkg::ST_CMD;
                end
            end
            kfd_pkg::ST_CMD:
            begin
                held_next = '0;
                if (byte_data != kfd_pkg::KISS_FEND)
                begin
                    state_next = (byte_data == kfd_pkg::KISS_CMD_DATA) ?
                                 kfd_pkg::ST_DATA : kfd_pkg::ST_HUNT;
                end
            end
            kfd_pkg::ST_DATA:
            begin
                if (byte_data == kfd_pkg::KISS_FESC)
                begin
                    state_next = kfd_pkg::ST_ESCAPE;
                end
                else if (byte_data == kfd_pkg::KISS_FEND)
                begin
                    addr_mode_next  = 1'b1;
                    held_next       = 9'({1'b0, index_reg} + 1'b1);
                    index_next      = '0;
                    res.frame_ready = 1'b1;
                    state_next      = kfd_pkg::ST_CMD;
                end
                else
                begin
                    do_put = 1'b1;
                end
            end
            kfd_pkg::ST_ESCAPE:
            begin
                if (byte_data == kfd_pkg::KISS_TFEND)
                begin
                    do_put     = 1'b1;
                    put_byte   = kfd_pkg::KISS_FEND;
                    state_next = kfd_pkg::ST_DATA;
                end
                else if (byte_data == kfd_pkg::KISS_TFESC)
                begin
                    do_put     = 1'b1;
                    put_byte   = kfd_pkg::KISS_FESC;
                    state_next = kfd_pkg::ST_DATA;
                end
                else
                begin
                    index_next        = '0;
                    res.frame_aborted = 1'b1;
                    state_next        = kfd_pkg::ST_HUNT;
                end
            end
            default:
            begin
                state_next = kfd_pkg::ST_HUNT;
            end
        endcase

        // A byte that arrives with the buffer full is dropped silently.
        if (do_put && (index_reg < kfd_pkg::IDX_W'(kfd_pkg::BUFFER_SIZE)))
        begin
            res.store_valid = 1'b1;
            res.store_index = 8'(index_reg);
            index_next      = index_reg + 1'b1;
            if (addr_mode_reg)
            begin
                addr_mode_next = !put_byte[0];
                res.store_byte = put_byte >> 1;
            end
            else
            begin
                res.store_byte = put_byte;
            end
        end

        res.frame_length = held_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        index_reg <= kfd_pkg::IDX_W'(kfd_pkg::BUFFER_SIZE))
        else $error("write index ran past the buffer size");

    assert property (@(posedge clk) disable iff (!rst_n)
        step && res.frame_ready |=> index_reg == '0 && addr_mode_reg
                                    && state_reg == kfd_pkg::ST_CMD)
        else $error("closing FEND did not restart the frame");

    assert property (@(posedge clk) disable iff (!rst_n)
        step && res.frame_aborted |=> index_reg == '0 && state_reg == kfd_pkg::ST_HUNT)
        else $error("abort did not return to hunting");

    assert property (@(posedge clk) disable iff (!rst_n)
        $countones({res.store_valid, res.frame_ready, res.frame_aborted}) <= 1)
        else $error("more than one event reported for one byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        step && res.store_valid |=> index_reg == $past(index_reg) + 1'b1)
        else $error("stored byte did not advance the write index");

endmodule

[sv/kfd_out_stage.sv]
`timescale 1ns / 1ps

module kfd_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_valid,
    input  kfd_pkg::result_t  res,
    output logic              res_take,
    kfd_result_if.source      result
);

    logic             valid_reg;
    logic             valid_next;
    kfd_pkg::result_t res_reg;

    assign res_take   = res_valid && (!valid_reg || result.ready);
    assign valid_next = res_take || (valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            res_reg <= res;
        end
    end

    assign result.valid         = valid_reg;
    assign result.store_valid   = res_reg.store_valid;
    assign result.store_byte    = res_reg.store_byte;
    assign result.store_index   = res_reg.store_index;
    assign result.frame_ready   = res_reg.frame_ready;
    assign result.frame_aborted = res_reg.frame_aborted;
    assign result.frame_length  = res_reg.frame_length;

endmodule

[tb/kfd_deframe_checker.sv]
`timescale 1ns / 1ps

module kfd_deframe_checker
    import kfd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    kfd_byte_if   rx,
    kfd_result_if result,
    output int    fail_count,
    output int    outstanding
);

    parse_state_t parse_st   = ST_HUNT;
    int unsigned  write_idx  = 0;
    logic         in_address = 1'b1;
    int unsigned  held_len   = 0;
    int unsigned  result_no  = 0;
    result_t      predicted_results [$];
    result_t      oldest;

    initial
    begin
        fail_count  = 0;
        outstanding = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
            report_mismatch($sformatf("result %0d: %s expected 0x%0h, got 0x%0h",
                                      result_no, name, want, got));
    endtask

    // Bytes past the end of the buffer are dropped and leave the address mode alone.
    function automatic void store_data(input logic [7:0] b, inout result_t r);
        logic [7:0] d;
        d = b;
        if (write_idx < BUFFER_SIZE)
        begin
            if (in_address)
            begin
                in_address = ~b[0];
                d          = b >> 1;
            end
            r.store_valid = 1'b1;
            r.store_byte  = d;
            r.store_index = 8'(write_idx);
            write_idx++;
        end
    endfunction

    function automatic result_t deframe_step(input logic [7:0] b);
        result_t r;
        r = '0;
        case (parse_st)
            ST_HUNT:
            begin
                if (b == KISS_FEND)
                    parse_st = ST_CMD;
            end
            ST_CMD:
            begin
                held_len = 0;
                if (b != KISS_FEND)
                    parse_st = (b == KISS_CMD_DATA) ? ST_DATA : ST_HUNT;
            end
            ST_DATA:
            begin
                if (b == KISS_FESC)
                    parse_st = ST_ESCAPE;
                else if (b == KISS_FEND)
                begin
                    in_address    = 1'b1;
                    held_len      = write_idx + 1;
                    write_idx     = 0;
                    r.frame_ready = 1'b1;
                    parse_st      = ST_CMD;
                end
                else
                    store_data(b, r);
            end
            default:
            begin
                if (b == KISS_TFEND)
                begin
                    store_data(KISS_FEND, r);
                    parse_st = ST_DATA;
                end
                else if (b == KISS_TFESC)
                begin
                    store_data(KISS_FESC, r);
                    parse_st = ST_DATA;
                end
                else
                begin
                    write_idx       = 0;
                    r.frame_aborted = 1'b1;
                    parse_st        = ST_HUNT;
                end
            end
        endcase
        r.frame_length = 9'(held_len);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_st   = ST_HUNT;
            write_idx  = 0;
            in_address = 1'b1;
            held_len   = 0;
            predicted_results.delete();
            outstanding = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (predicted_results.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              result_no));
                else
                begin
                    oldest = predicted_results.pop_front();
                    check_field("store_valid", oldest.store_valid, result.store_valid);
                    check_field("store_byte", oldest.store_byte, result.store_byte);
                    check_field("store_index", oldest.store_index, result.store_index);
                    check_field("frame_ready", oldest.frame_ready, result.frame_ready);
                    check_field("frame_aborted", oldest.frame_aborted,
                                result.frame_aborted);
                    check_field("frame_length", oldest.frame_length, result.frame_length);
                end
                result_no++;
            end
            if (rx.valid && rx.ready)
                predicted_results.push_back(deframe_step(rx.rx_byte));
            outstanding = predicted_results.size();
        end
    end

endmodule

[tb/kiss_frame_deframer_tb.sv]
`timescale 1ns / 1ps

module kiss_frame_deframer_tb;
    import kfd_pkg::*;

    localparam int RANDOM_ITEMS = 1850;
    localparam int CALM_TAIL    = 200;

    logic clk = 1'b0;
    logic rst_n;
    int   fail_count;
    int   outstanding;
    int   items_sent;
    int   frame_no;
    bit   idle_on;
    bit   stall_on;

    logic [7:0] directed_bytes [25] = '{
        8'h12, KISS_FEND, KISS_FEND, KISS_CMD_DATA, 8'h00, 8'hFF, 8'h41,
        KISS_FESC, KISS_TFEND, KISS_FESC, KISS_TFESC, KISS_FEND,
        KISS_CMD_DATA, KISS_FEND, 8'h07,
        KISS_FEND, KISS_CMD_DATA, 8'h01, KISS_FESC, 8'h55,
        KISS_FEND, KISS_CMD_DATA, 8'h02, KISS_FESC, KISS_FEND
    };

    kfd_byte_if   rx_if ();
    kfd_result_if res_if ();

    kiss_frame_deframer u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_if),
        .result (res_if)
    );

    kfd_deframe_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx          (rx_if),
        .result      (res_if),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    task automatic send_byte(input logic [7:0] b);
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge clk);
        while (!rx_if.ready)
            @(posedge clk);
        items_sent++;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    task automatic send_data_byte(input logic [7:0] d);
        if (d == KISS_FEND)
        begin
            send_byte(KISS_FESC);
            send_byte(KISS_TFEND);
        end
        else if (d == KISS_FESC)
        begin
            send_byte(KISS_FESC);
            send_byte(KISS_TFESC);
        end
        else
            send_byte(d);
    endtask

    // The first bytes form an address field: low bit clear except on its last byte.
    task automatic send_frame(input int len, input logic [7:0] cmd, input bit corrupt);
        int         addr_len;
        int         bad_at;
        logic [7:0] d;
        logic [7:0] bad;
        addr_len = $urandom_range(1, 8);
        bad_at   = corrupt ? $urandom_range(0, len) : -1;
        send_byte(KISS_FEND);
        if ($urandom_range(0, 7) == 0)
            send_byte(KISS_FEND);
        send_byte(cmd);
        for (int i = 0; i <= len; i++)
        begin
            if (i == bad_at)
            begin
                bad = $urandom_range(0, 1) ? KISS_FEND : KISS_FESC;
                if ($urandom_range(0, 2) != 0)
                    do
                        bad = 8'($urandom_range(0, 255));
                    while (bad == KISS_TFEND || bad == KISS_TFESC);
                send_byte(KISS_FESC);
                send_byte(bad);
            end
            if (i < len)
            begin
                d = 8'($urandom_range(0, 255));
                case ($urandom_range(0, 9))
                    0: d = KISS_FEND;
                    1: d = KISS_FESC;
                    default: ;
                endcase
                if (i < addr_len - 1)
                    d[0] = 1'b0;
                else if (i == addr_len - 1)
                    d[0] = 1'b1;
                send_data_byte(d);
            end
        end
        send_byte(KISS_FEND);
    endtask

    task automatic wait_drained();
        rx_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    initial
    begin
        res_if.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (stall_on && $urandom_range(0, 5) == 0)
            begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                res_if.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        rst_n         <= 1'b0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= 8'h00;
        idle_on  = 1'b1;
        stall_on = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);

        items_sent = 0;
        frame_no   = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            idle_on  = (items_sent < RANDOM_ITEMS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
            stall_on = (items_sent < RANDOM_ITEMS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
            if (frame_no == 20)
                wait_drained();
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            if (frame_no % 45 == 5)
                send_frame($urandom_range(250, 300), KISS_CMD_DATA, 1'b0);
            else
                send_frame($urandom_range(0, 24),
                           ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255))
                                                       : KISS_CMD_DATA,
                           $urandom_range(0, 14) == 0);
            frame_no++;
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[kiss_frame_deframer.f]
sv/kfd_pkg.sv
sv/kfd_byte_if.sv
sv/kfd_result_if.sv
sv/kfd_in_stage.sv
sv/kfd_fsm.sv
sv/kfd_out_stage.sv
sv/kiss_frame_deframer.sv
tb/kfd_deframe_checker.sv
tb/kiss_frame_deframer_tb.sv
